// ===== sv/source_reputation_tracker_defines.svh =====
// assertion macros used by the reputation tracker datapath
`ifndef SOURCE_REPUTATION_TRACKER_DEFINES_SVH
`define SOURCE_REPUTATION_TRACKER_DEFINES_SVH

// same-cycle implication, sampled on aclk
`define SRT_ASSERT_IMP(lbl, rstn, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on aclk
`define SRT_ASSERT_NXT(lbl, rstn, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/srt_pkg.sv =====
// types and constants of the source reputation tracker
package srt_pkg;

    localparam int ADDR_W     = 32;
    localparam int DELTA_W    = 8;
    localparam int TIME_W     = 32;
    localparam int SCORE_W    = 7;
    localparam int SUM_W      = 10;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 48;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // remainder unit: bits of the address consumed per cycle
    localparam int DIV_BITS   = 8;
    localparam int DIV_STEPS  = ADDR_W / DIV_BITS;
    localparam int DIV_CNT_W  = 2;

    localparam logic [SCORE_W-1:0] SCORE_MAX     = 7'd100;
    localparam logic [TIME_W-1:0]  DURATION_RST  = 32'd3600;
    localparam logic [SCORE_W-1:0] THRESHOLD_RST = 7'd10;
    localparam logic [SCORE_W-1:0] INIT_RST      = 7'd50;

    typedef enum logic [1:0] {
        CFG_DURATION   = 2'd0,
        CFG_THRESHOLD  = 2'd1,
        CFG_INIT_SCORE = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [ADDR_W-1:0]   addr;
        logic [SCORE_W-1:0]  score;
        logic                blocked;
        logic [TIME_W-1:0]   expiry;
    } way_t;

    typedef struct packed {
        logic load;
        logic rd_direct;
        logic div_step;
        logic rd_div;
        logic commit;
        logic clr_wr;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage

// ===== sv/source_reputation_tracker.sv =====
// with BUCKETS a power of two the row is read by the low address bits as a beat is taken,
// else after the address remainder unit, 8 bits per cycle; beats are taken one at a time,
// s_tready low until the read then write of its bucket row on the table ram commits once
// the result register is free; the next beat is taken while a result waits
// reset: synchronous, active low; a clearing pass writes every bucket row, one per
// cycle, with s_tready low; config writes are taken meanwhile
module source_reputation_tracker #(
    parameter int BUCKETS = 4096,
    parameter int WAYS    = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // src_addr[31:0], delta[39:32], now_seconds[71:40]
    input  logic [srt_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // score[6:0], blacklisted[7], newly_blacklisted[8], expiry[40:9], created[41],
    // table_full[42], zero[47:43]
    output logic [srt_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [srt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [srt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import srt_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    cfg_idx_t            cfg_idx;
    logic                cfg_wr;
    logic [TIME_W-1:0]   duration_reg;
    logic [SCORE_W-1:0]  threshold_reg;
    logic [SCORE_W-1:0]  init_reg;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg  <= DURATION_RST;
            threshold_reg <= THRESHOLD_RST;
            init_reg      <= INIT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_DURATION:   duration_reg  <= pwdata;
                CFG_THRESHOLD:  threshold_reg <= pwdata[SCORE_W-1:0];
                CFG_INIT_SCORE: init_reg      <= pwdata[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            CFG_DURATION:   prdata = duration_reg;
            CFG_THRESHOLD:  prdata = {{(APB_DATA_W - SCORE_W){1'b0}}, threshold_reg};
            CFG_INIT_SCORE: prdata = {{(APB_DATA_W - SCORE_W){1'b0}}, init_reg};
            default:        prdata = '0;
        endcase
    end

    srt_ctrl #(
        .BUCKETS (BUCKETS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srt_datapath #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_duration  (duration_reg),
        .cfg_threshold (threshold_reg),
        .cfg_init      (init_reg)
    );

endmodule

// ===== sv/srt_ram.sv =====
// generic single-write, single-read ram with registered read data
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/srt_ctrl.sv =====
// controller state machine of the reputation tracker
module srt_ctrl #(
    parameter int BUCKETS = 4096
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  srt_pkg::stat_t stat,
    output srt_pkg::cmd_t  cmd
);
    import srt_pkg::*;

    localparam bit DIRECT = (BUCKETS & (BUCKETS - 1)) == 0;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (DIRECT) begin
                        cmd.rd_direct = 1'b1;
                        state_next    = ST_UPDATE;
                    end else begin
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.rd_div = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== sv/srt_datapath.sv =====
// datapath: bucket index, table ram, score update and result register
`include "source_reputation_tracker_defines.svh"

module srt_datapath #(
    parameter int BUCKETS = 4096,
    parameter int WAYS    = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  srt_pkg::cmd_t                   cmd,
    output srt_pkg::stat_t                  stat,
    input  logic [srt_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srt_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic [srt_pkg::TIME_W-1:0]      cfg_duration,
    input  logic [srt_pkg::SCORE_W-1:0]     cfg_threshold,
    input  logic [srt_pkg::SCORE_W-1:0]     cfg_init
);
    import srt_pkg::*;

    localparam int ROW_W    = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
    localparam int IDX_W    = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int ROW_BITS = WAYS * $bits(way_t);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BUCKETS - 1);
    localparam logic [ROW_W:0]   BKT_C    = (ROW_W + 1)'(BUCKETS);

    logic [ADDR_W-1:0]         in_addr;
    logic [ROW_W-1:0]          direct_row;

    logic [ADDR_W-1:0]         item_addr_reg;
    logic [DELTA_W-1:0]        item_delta_reg;
    logic [TIME_W-1:0]         item_now_reg;
    logic [ADDR_W-1:0]         div_sh_reg;
    logic [ROW_W-1:0]          rem_reg;
    logic [ROW_W-1:0]          rem_next;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic [ROW_W-1:0]          clr_cnt_reg;
    logic [ROW_W-1:0]          row_addr_reg;

    logic                      rd_en;
    logic [ROW_W-1:0]          rd_addr;
    logic                      wr_en;
    logic [ROW_W-1:0]          wr_addr;
    logic [ROW_BITS-1:0]       wr_data;
    logic [ROW_BITS-1:0]       rd_data;

    way_t [WAYS-1:0]           row_q;
    way_t [WAYS-1:0]           new_row;

    logic                      hit_any;
    logic                      free_any;
    logic                      full_flag;
    logic [IDX_W-1:0]          hit_idx;
    logic [IDX_W-1:0]          free_idx;
    logic [IDX_W-1:0]          sel;
    logic [SCORE_W-1:0]        base_score;
    logic                      base_blocked;
    logic [TIME_W-1:0]         base_expiry;
    logic signed [SUM_W-1:0]   sum_v;
    logic [SCORE_W-1:0]        sat_score;
    logic                      newly;
    logic                      blocked_new;
    logic [TIME_W-1:0]         expiry_new;
    logic [M_DATA_W-1:0]       result;

    logic                      m_tvalid_reg;
    logic [M_DATA_W-1:0]       m_tdata_reg;

    assign in_addr    = s_tdata[ADDR_W-1:0];
    assign direct_row = (BUCKETS == 1) ? '0 : in_addr[ROW_W-1:0];

    // address remainder, several bits of restoring division per cycle
    always_comb begin
        logic [ROW_W:0]   t;
        logic [ROW_W-1:0] r;
        r = rem_reg;
        for (int k = 0; k < DIV_BITS; k++) begin
            t = {r, div_sh_reg[ADDR_W-1-k]};
            if (t >= BKT_C) begin
                t = t - BKT_C;
            end
            r = t[ROW_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_addr_reg  <= in_addr;
            item_delta_reg <= s_tdata[ADDR_W+DELTA_W-1:ADDR_W];
            item_now_reg   <= s_tdata[ADDR_W+DELTA_W+TIME_W-1:ADDR_W+DELTA_W];
            div_sh_reg     <= in_addr;
            rem_reg        <= '0;
        end else if (cmd.div_step) begin
            div_sh_reg <= div_sh_reg << DIV_BITS;
            rem_reg    <= rem_next;
        end
        if (rd_en) begin
            row_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign rd_en   = cmd.rd_direct | cmd.rd_div;
    assign rd_addr = cmd.rd_direct ? direct_row : rem_reg;

    srt_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (BUCKETS)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign row_q = rd_data;

    // lowest matching way and lowest free way
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row_q[w].valid && row_q[w].addr == item_addr_reg) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(w);
            end
            if (!row_q[w].valid) begin
                free_any = 1'b1;
                free_idx = IDX_W'(w);
            end
        end
    end

    assign full_flag    = !hit_any && !free_any;
    assign sel          = hit_any ? hit_idx : free_idx;
    assign base_score   = hit_any ? row_q[sel].score : cfg_init;
    assign base_blocked = hit_any ? row_q[sel].blocked : 1'b0;
    assign base_expiry  = hit_any ? row_q[sel].expiry : '0;

    assign sum_v = $signed({{(SUM_W - SCORE_W){1'b0}}, base_score})
                 + $signed({{(SUM_W - DELTA_W){item_delta_reg[DELTA_W-1]}}, item_delta_reg});

    always_comb begin
        if (sum_v[SUM_W-1]) begin
            sat_score = '0;
        end else if (sum_v > $signed({{(SUM_W - SCORE_W){1'b0}}, SCORE_MAX})) begin
            sat_score = SCORE_MAX;
        end else begin
            sat_score = sum_v[SCORE_W-1:0];
        end
    end

    assign newly       = (sat_score < cfg_threshold) && !base_blocked;
    assign blocked_new = base_blocked | newly;
    assign expiry_new  = newly ? item_now_reg + cfg_duration : base_expiry;

    always_comb begin
        new_row              = row_q;
        new_row[sel].valid   = 1'b1;
        new_row[sel].addr    = item_addr_reg;
        new_row[sel].score   = sat_score;
        new_row[sel].blocked = blocked_new;
        new_row[sel].expiry  = expiry_new;
    end

    assign wr_en   = cmd.clr_wr | (cmd.commit & !full_flag);
    assign wr_addr = cmd.clr_wr ? clr_cnt_reg : row_addr_reg;
    assign wr_data = cmd.clr_wr ? '0 : new_row;

    always_comb begin
        result = '0;
        if (full_flag) begin
            result[42] = 1'b1;
        end else begin
            result[6:0]  = sat_score;
            result[7]    = blocked_new;
            result[8]    = newly;
            result[40:9] = expiry_new;
            result[41]   = !hit_any;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.clr_last = clr_cnt_reg == LAST_ROW;
    assign stat.div_last = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign stat.out_free = !m_tvalid_reg || m_tready;

    `SRT_ASSERT_IMP(a_commit_free, aresetn, cmd.commit, !m_tvalid_reg || m_tready)
    `SRT_ASSERT_NXT(a_commit_shows, aresetn, cmd.commit, m_tvalid_reg)
    `SRT_ASSERT_IMP(a_full_no_write, aresetn, cmd.commit && full_flag, !wr_en)
    `SRT_ASSERT_IMP(a_newly_marked, aresetn, m_tvalid_reg && m_tdata_reg[8], m_tdata_reg[7])

endmodule

// ===== tb/tb_source_reputation_tracker.sv =====
// self-checking testbench for the source reputation tracker: stream traffic, apb setup, scoring
module tb_source_reputation_tracker;
    import srt_pkg::*;

    localparam int N_BUCKETS   = 4096;
    localparam int N_WAYS      = 4;
    localparam int N_ENTRIES   = N_BUCKETS * N_WAYS;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic              table_full;
        logic              created;
        logic [TIME_W-1:0] expiry;
        logic              newly_blacklisted;
        logic              blacklisted;
        logic [SCORE_W-1:0] score;
    } outcome_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // src_addr[31:0], delta[39:32], now_seconds[71:40]
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // score[6:0], blacklisted[7], newly_blacklisted[8], expiry[40:9], created[41],
    // table_full[42], zero[47:43]
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow of the reputation table and its settings
    logic [TIME_W-1:0]  cur_duration;
    logic [SCORE_W-1:0] cur_threshold;
    logic [SCORE_W-1:0] cur_init_score;
    logic               tab_valid   [N_ENTRIES];
    logic [ADDR_W-1:0]  tab_addr    [N_ENTRIES];
    logic [SCORE_W-1:0] tab_score   [N_ENTRIES];
    logic               tab_blocked [N_ENTRIES];
    logic [TIME_W-1:0]  tab_expiry  [N_ENTRIES];

    outcome_t pending_verdicts[$];

    logic [19:0] hot_tags    [6];
    logic [11:0] hot_buckets [16];

    bit src_idle;
    bit sink_idle;
    int sink_stall;
    int fail_count;
    int cycle_count;
    int items_sent;
    int verdicts_seen;
    int full_seen;
    int blacklist_seen;
    int settings_used;

    source_reputation_tracker #(
        .BUCKETS(N_BUCKETS),
        .WAYS   (N_WAYS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic outcome_t rate_source(logic [ADDR_W-1:0] addr,
                                             logic [DELTA_W-1:0] delta,
                                             logic [TIME_W-1:0] now);
        outcome_t v;
        int base;
        int slot;
        int sum;
        bit found;
        v = '0;
        base = int'(addr % N_BUCKETS) * N_WAYS;
        found = 1'b0;
        slot = 0;
        for (int w = 0; w < N_WAYS; w++) begin
            if (!found && tab_valid[base+w] && tab_addr[base+w] == addr) begin
                slot = base + w;
                found = 1'b1;
            end
        end
        if (!found) begin
            for (int w = 0; w < N_WAYS; w++) begin
                if (!found && !tab_valid[base+w]) begin
                    slot = base + w;
                    found = 1'b1;
                end
            end
            if (!found) begin
                v.table_full = 1'b1;
                return v;
            end
            tab_valid[slot]   = 1'b1;
            tab_addr[slot]    = addr;
            tab_score[slot]   = cur_init_score;
            tab_blocked[slot] = 1'b0;
            tab_expiry[slot]  = '0;
            v.created = 1'b1;
        end
        sum = int'(tab_score[slot]) + int'($signed(delta));
        if (sum > int'(SCORE_MAX))
            sum = int'(SCORE_MAX);
        if (sum < 0)
            sum = 0;
        tab_score[slot] = SCORE_W'(sum);
        if (tab_score[slot] < cur_threshold && !tab_blocked[slot]) begin
            tab_blocked[slot] = 1'b1;
            tab_expiry[slot]  = now + cur_duration;
            v.newly_blacklisted = 1'b1;
        end
        v.score       = tab_score[slot];
        v.blacklisted = tab_blocked[slot];
        v.expiry      = tab_expiry[slot];
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return {hot_tags[$urandom_range(0, 5)], hot_buckets[$urandom_range(0, 15)]};
    endfunction

    function automatic logic [DELTA_W-1:0] pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return DELTA_W'($urandom());
        if (r < 35)
            return DELTA_W'(int'($urandom_range(0, 30)) - 20);
        return DELTA_W'(int'($urandom_range(0, 200)) - 100);
    endfunction

    function automatic logic [TIME_W-1:0] pick_now();
        if ($urandom_range(0, 9) == 0)
            return 32'hFFFF_FF00 | $urandom_range(0, 255);
        return $urandom();
    endfunction

    task automatic send_item(logic [ADDR_W-1:0] addr, logic [DELTA_W-1:0] delta,
                             logic [TIME_W-1:0] now);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        for (int i = 0; i < gap; i++) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {now, delta, addr};
        do
            @(posedge aclk);
        while (!s_tready);
        pending_verdicts.push_back(rate_source(addr, delta, now));
        items_sent++;
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_item(pick_addr(), pick_delta(), pick_now());
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(bit is_write, cfg_idx_t idx, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(cfg_idx_t idx, logic [APB_DATA_W-1:0] want, int width);
        logic [APB_DATA_W-1:0] got;
        logic [APB_DATA_W-1:0] mask;
        apb_access(1'b0, idx, '0, got);
        mask = (width >= APB_DATA_W) ? '1 : ((APB_DATA_W'(1) << width) - 1);
        if ((got & mask) != (want & mask)) begin
            $error("register %s: expected %0d, got %0d", idx.name(), want & mask, got & mask);
            fail_count++;
        end
    endtask

    task automatic set_config(logic [31:0] duration, logic [31:0] threshold,
                              logic [31:0] init_score);
        logic [APB_DATA_W-1:0] unused;
        // upper bits are noise; the block keeps only the register width
        apb_access(1'b1, CFG_DURATION, duration, unused);
        apb_access(1'b1, CFG_THRESHOLD, threshold, unused);
        apb_access(1'b1, CFG_INIT_SCORE, init_score, unused);
        cur_duration   = duration;
        cur_threshold  = threshold[SCORE_W-1:0];
        cur_init_score = init_score[SCORE_W-1:0];
        check_register(CFG_DURATION, cur_duration, TIME_W);
        check_register(CFG_THRESHOLD, 32'(cur_threshold), SCORE_W);
        check_register(CFG_INIT_SCORE, 32'(cur_init_score), SCORE_W);
        settings_used++;
    endtask

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = outcome_t'(m_tdata[$bits(outcome_t)-1:0]);
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no pending item");
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                report_field("score", 32'(want.score), 32'(got.score));
                report_field("blacklisted", 32'(want.blacklisted), 32'(got.blacklisted));
                report_field("newly_blacklisted", 32'(want.newly_blacklisted),
                             32'(got.newly_blacklisted));
                report_field("expiry", want.expiry, got.expiry);
                report_field("created", 32'(want.created), 32'(got.created));
                report_field("table_full", 32'(want.table_full), 32'(got.table_full));
                verdicts_seen++;
                full_seen      += int'(want.table_full);
                blacklist_seen += int'(want.newly_blacklisted);
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            m_tready <= 1'b0;
        end else if (sink_idle && $urandom_range(0, 4) == 0) begin
            sink_stall = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic test_register_defaults();
        check_register(CFG_DURATION, DURATION_RST, TIME_W);
        check_register(CFG_THRESHOLD, 32'(THRESHOLD_RST), SCORE_W);
        check_register(CFG_INIT_SCORE, 32'(INIT_RST), SCORE_W);
    endtask

    task automatic test_directed();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_item(32'h0000_0000, 8'd0, 32'h0000_0000);
        send_item(32'hFFFF_FFFF, 8'h7F, 32'hFFFF_FFFF);
        // drop to zero blacklists, later drops must not re-arm the mark
        send_item(32'h0000_0000, 8'h80, 32'h0000_0100);
        send_item(32'h0000_0000, 8'd100, 32'h0000_0200);
        send_item(32'h0000_0000, -8'sd100, 32'h0000_0300);
        send_item(32'hFFFF_FFFF, 8'h81, 32'h1234_5678);
        // fill one bucket, then one more address than it holds
        for (int k = 1; k <= N_WAYS + 1; k++)
            send_item({20'(k), 12'h123}, 8'd5, 32'd10);
        send_item({20'd3, 12'h123}, -8'sd20, 32'd11);
        // expiry wraps past the top of time
        send_item({20'd1, 12'h123}, -8'sd60, 32'hFFFF_FFF0);
        // score exactly at threshold stays clean, one below blacklists
        send_item(32'h0ABC_D456, -8'sd40, 32'd1000);
        send_item(32'h0ABC_D456, -8'sd1, 32'd1001);
        send_item(32'h0ABC_D456, 8'd1, 32'd1002);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        set_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(32'h5555_0AAA, -8'sd100, 32'hFFFF_FFFF);
        send_random(40);
        wait_drained();
        // start above the ceiling, every score under the threshold
        set_config(32'hFFFF_FFFF, 32'hFFFF_FF7F, 32'hFFFF_FF7F);
        send_item(32'h5555_1AAA, 8'd0, 32'h0000_0002);
        send_random(40);
        wait_drained();
        set_config(32'h0000_0000, 32'd100, 32'd100);
        send_item(32'h5555_2AAA, 8'h7F, 32'h0000_0003);
        send_random(40);
        wait_drained();
        set_config(32'hFFFF_FFFF, 32'd101, 32'd0);
        send_random(40);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [31:0] thr;
        for (int phase = 0; phase < 12; phase++) begin
            thr = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 60);
            set_config($urandom(), thr, ($urandom_range(0, 4) == 0) ? $urandom()
                                                                  : $urandom_range(20, 100));
            src_idle  = (phase % 4) != 1;
            sink_idle = (phase % 4) != 2;
            send_random(100);
            wait_drained();
        end
    endtask

    initial begin
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cur_duration   = DURATION_RST;
        cur_threshold  = THRESHOLD_RST;
        cur_init_score = INIT_RST;
        for (int e = 0; e < N_ENTRIES; e++)
            tab_valid[e] = 1'b0;
        foreach (hot_tags[i])
            hot_tags[i] = 20'($urandom());
        foreach (hot_buckets[i])
            hot_buckets[i] = 12'($urandom());
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_register_defaults();
        test_directed();
        test_config_extremes();
        test_random_traffic();

        $display("%0d items scored, %0d results checked under %0d register settings",
                 items_sent, verdicts_seen, settings_used);
        $display("%0d new blacklist marks, %0d full-bucket rejects", blacklist_seen, full_seen);
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
